/* hw/rtl/fraction_gcd_reducer_top_defines.svh */
// Assertion macros for the fraction reducer checker.
`ifndef FRACTION_GCD_REDUCER_TOP_DEFINES_SVH
`define FRACTION_GCD_REDUCER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FGR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/fgr_pkg.sv */
// Types, constants and microcode encodings for the fraction reducer.
`default_nettype none

package fgr_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAG_W       = VALUE_WIDTH - 1;
  localparam int CNT_W       = $clog2(MAG_W);
  localparam int STEP_W      = 4;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] numerator;
    logic signed [VALUE_WIDTH-1:0] denominator;
  } fgr_in_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] reduced_numerator;
    logic [MAG_W-1:0]              reduced_denominator;
    logic                          is_whole;
    logic                          divide_error;
  } fgr_out_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP        = 4'd0,
    OP_LOAD       = 4'd1,
    OP_HALVE_BOTH = 4'd2,
    OP_HALVE_A    = 4'd3,
    OP_HALVE_B    = 4'd4,
    OP_SUB        = 4'd5,
    OP_MAKE_G     = 4'd6,
    OP_DIV        = 4'd7,
    OP_DONE       = 4'd8,
    OP_ERR        = 4'd9,
    OP_ZERO       = 4'd10
  } fgr_op_t;

  // jump conditions
  typedef enum logic [3:0] {
    COND_NEVER     = 4'd0,
    COND_ALWAYS    = 4'd1,
    COND_NO_START  = 4'd2,
    COND_D_ZERO    = 4'd3,
    COND_N_ZERO    = 4'd4,
    COND_BOTH_EVEN = 4'd5,
    COND_A_EVEN    = 4'd6,
    COND_B_EVEN    = 4'd7,
    COND_A_NE_B    = 4'd8,
    COND_DIV_MORE  = 4'd9
  } fgr_cond_t;

  // program addresses
  localparam logic [STEP_W-1:0] STEP_IDLE = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_CHKD = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_CHKN = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_TZ   = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_AODD = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_BODD = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_SUB  = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_GCD  = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_DIV  = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_DONE = STEP_W'(9);
  localparam logic [STEP_W-1:0] STEP_ERR  = STEP_W'(10);
  localparam logic [STEP_W-1:0] STEP_ZERO = STEP_W'(11);

  typedef struct packed {
    fgr_op_t           op;
    fgr_cond_t         cond;
    logic [STEP_W-1:0] target;
  } fgr_ucw_t;

  typedef struct packed {
    logic d_zero;
    logic n_zero;
    logic a_even;
    logic b_even;
    logic a_ne_b;
    logic div_last;
  } fgr_status_t;

endpackage

`default_nettype wire

/* hw/rtl/fgr_seq.sv */
// Microcode sequencer: program ROM, step counter and jump logic.
`default_nettype none

module fgr_seq (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire fgr_pkg::fgr_status_t status,
  output fgr_pkg::fgr_ucw_t   ctl,
  output logic                busy
);
  import fgr_pkg::*;

  logic [STEP_W-1:0] pc_r;
  logic [STEP_W-1:0] pc_nxt;
  logic              take;

  // program: a jump is taken when cond holds, otherwise fall through
  function automatic fgr_ucw_t ucode(input logic [STEP_W-1:0] step);
    fgr_ucw_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: w = '{op: OP_LOAD,       cond: COND_NO_START,  target: STEP_IDLE};
      STEP_CHKD: w = '{op: OP_NOP,        cond: COND_D_ZERO,    target: STEP_ERR};
      STEP_CHKN: w = '{op: OP_NOP,        cond: COND_N_ZERO,    target: STEP_ZERO};
      STEP_TZ:   w = '{op: OP_HALVE_BOTH, cond: COND_BOTH_EVEN, target: STEP_TZ};
      STEP_AODD: w = '{op: OP_HALVE_A,    cond: COND_A_EVEN,    target: STEP_AODD};
      STEP_BODD: w = '{op: OP_HALVE_B,    cond: COND_B_EVEN,    target: STEP_BODD};
      STEP_SUB:  w = '{op: OP_SUB,        cond: COND_A_NE_B,    target: STEP_BODD};
      STEP_GCD:  w = '{op: OP_MAKE_G,     cond: COND_NEVER,     target: STEP_IDLE};
      STEP_DIV:  w = '{op: OP_DIV,        cond: COND_DIV_MORE,  target: STEP_DIV};
      STEP_DONE: w = '{op: OP_DONE,       cond: COND_ALWAYS,    target: STEP_IDLE};
      STEP_ERR:  w = '{op: OP_ERR,        cond: COND_ALWAYS,    target: STEP_IDLE};
      STEP_ZERO: w = '{op: OP_ZERO,       cond: COND_ALWAYS,    target: STEP_IDLE};
      default:   w = '{op: OP_NOP,        cond: COND_ALWAYS,    target: STEP_IDLE};
    endcase
    return w;
  endfunction

  assign ctl  = ucode(pc_r);
  assign busy = (pc_r != STEP_IDLE);

  always_comb begin
    unique case (ctl.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_START:  take = !start;
      COND_D_ZERO:    take = status.d_zero;
      COND_N_ZERO:    take = status.n_zero;
      COND_BOTH_EVEN: take = status.a_even && status.b_even;
      COND_A_EVEN:    take = status.a_even;
      COND_B_EVEN:    take = status.b_even;
      COND_A_NE_B:    take = status.a_ne_b;
      COND_DIV_MORE:  take = !status.div_last;
      default:        take = 1'b1;
    endcase
    pc_nxt = take ? ctl.target : pc_r + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fgr_datapath.sv */
// Datapath: operand registers, binary GCD unit, two-lane divider, result register.
`default_nettype none

module fgr_datapath (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire fgr_pkg::fgr_in_t  in_data,
  input  wire fgr_pkg::fgr_ucw_t ctl,
  output fgr_pkg::fgr_status_t status,
  output logic                out_valid,
  output fgr_pkg::fgr_out_t   out_data
);
  import fgr_pkg::*;

  logic [MAG_W-1:0] nmag_r, nmag_nxt;   // numerator magnitude, then its quotient
  logic [MAG_W-1:0] dmag_r, dmag_nxt;   // denominator magnitude, then its quotient
  logic             neg_r, neg_nxt;
  logic [MAG_W-1:0] a_r, a_nxt;
  logic [MAG_W-1:0] b_r, b_nxt;
  logic [MAG_W-1:0] g_r, g_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [MAG_W-1:0] rn_r, rn_nxt;
  logic [MAG_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  fgr_out_t         out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [MAG_W-1:0]       diff;
  logic                   a_gt_b;
  logic [VALUE_WIDTH-1:0] num_ext;
  logic [2*MAG_W-1:0]     lane_n, lane_d;

  // magnitude, with the most negative code held at the largest magnitude
  function automatic logic [MAG_W-1:0] sat_mag(input logic [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH-1:0] m;
    m = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
    return m[VALUE_WIDTH-1] ? {MAG_W{1'b1}} : m[MAG_W-1:0];
  endfunction

  // one restoring step: returns {remainder, dividend/quotient}
  function automatic logic [2*MAG_W-1:0] div_step(input logic [MAG_W-1:0] rem,
                                                  input logic [MAG_W-1:0] quo,
                                                  input logic [MAG_W-1:0] dvs);
    logic [MAG_W:0] trial;
    logic [MAG_W:0] sub;
    logic           ge;
    trial = {rem, quo[MAG_W-1]};
    sub   = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
    return {(ge ? sub[MAG_W-1:0] : trial[MAG_W-1:0]), quo[MAG_W-2:0], ge};
  endfunction

  assign a_gt_b  = (a_r > b_r);
  assign diff    = a_gt_b ? (a_r - b_r) : (b_r - a_r);
  assign num_ext = neg_r ? (~{1'b0, nmag_r} + 1'b1) : {1'b0, nmag_r};
  assign lane_n  = div_step(rn_r, nmag_r, g_r);
  assign lane_d  = div_step(rd_r, dmag_r, g_r);

  assign status.d_zero   = (dmag_r == '0);
  assign status.n_zero   = (nmag_r == '0);
  assign status.a_even   = !a_r[0];
  assign status.b_even   = !b_r[0];
  assign status.a_ne_b   = (a_r != b_r);
  assign status.div_last = (cnt_r == CNT_W'(MAG_W - 1));

  always_comb begin
    nmag_nxt      = nmag_r;
    dmag_nxt      = dmag_r;
    neg_nxt       = neg_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    g_nxt         = g_r;
    k_nxt         = k_r;
    rn_nxt        = rn_r;
    rd_nxt        = rd_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = 1'b0;
    unique case (ctl.op)
      OP_NOP: ;
      OP_LOAD: begin
        if (start) begin
          nmag_nxt = sat_mag(in_data.numerator);
          dmag_nxt = sat_mag(in_data.denominator);
          neg_nxt  = in_data.numerator[VALUE_WIDTH-1] ^ in_data.denominator[VALUE_WIDTH-1];
          a_nxt    = sat_mag(in_data.numerator);
          b_nxt    = sat_mag(in_data.denominator);
          k_nxt    = '0;
        end
      end
      OP_HALVE_BOTH: begin
        if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + CNT_W'(1);
        end
      end
      OP_HALVE_A: begin
        if (!a_r[0]) a_nxt = a_r >> 1;
      end
      OP_HALVE_B: begin
        if (!b_r[0]) b_nxt = b_r >> 1;
      end
      OP_SUB: begin
        // both odd: difference is even, drop one factor of two at once
        if (a_gt_b) a_nxt = b_r;
        b_nxt = diff >> 1;
      end
      OP_MAKE_G: begin
        g_nxt   = a_r << k_r;
        rn_nxt  = '0;
        rd_nxt  = '0;
        cnt_nxt = '0;
      end
      OP_DIV: begin
        rn_nxt   = lane_n[2*MAG_W-1:MAG_W];
        nmag_nxt = lane_n[MAG_W-1:0];
        rd_nxt   = lane_d[2*MAG_W-1:MAG_W];
        dmag_nxt = lane_d[MAG_W-1:0];
        cnt_nxt  = cnt_r + CNT_W'(1);
      end
      OP_DONE: begin
        out_data_nxt.reduced_numerator   = num_ext;
        out_data_nxt.reduced_denominator = dmag_r;
        out_data_nxt.is_whole            = (dmag_r == MAG_W'(1));
        out_data_nxt.divide_error        = 1'b0;
        out_valid_nxt                    = 1'b1;
      end
      OP_ERR: begin
        out_data_nxt.reduced_numerator   = '0;
        out_data_nxt.reduced_denominator = MAG_W'(1);
        out_data_nxt.is_whole            = 1'b1;
        out_data_nxt.divide_error        = 1'b1;
        out_valid_nxt                    = 1'b1;
      end
      OP_ZERO: begin
        out_data_nxt.reduced_numerator   = '0;
        out_data_nxt.reduced_denominator = MAG_W'(1);
        out_data_nxt.is_whole            = 1'b1;
        out_data_nxt.divide_error        = 1'b0;
        out_valid_nxt                    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    nmag_r     <= nmag_nxt;
    dmag_r     <= dmag_nxt;
    neg_r      <= neg_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    g_r        <= g_nxt;
    k_r        <= k_nxt;
    rn_r       <= rn_nxt;
    rd_r       <= rd_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* hw/rtl/fraction_gcd_reducer_top.sv */
// Top level of the fraction reducer: sequencer plus datapath.
`default_nettype none

// Reduces one signed fraction to lowest terms and gives the sign to the
// numerator, so the denominator comes out positive. A word is taken on a
// clock edge with start high and busy low; busy then stays high until the
// result is out. The result is shown on out_data for exactly one cycle with
// out_valid high. There is no back-pressure: the receiver must take it in
// that cycle. In the same cycle busy is already low, so a new word can be
// started while the result is on the port.
// Order of steps after the accepting edge, before out_valid is raised:
//   - zero denominator: checked first, result 0/1 with divide_error
//   - zero numerator: checked next, result 0/1
//   - otherwise the binary GCD loop runs, then the divider. The loop ends
//     after a single subtraction when both magnitudes are equal and odd.
//     Each halving and each subtraction shortens the operands by at least
//     one bit between them.
// Both quotients are formed side by side by the 31-step restoring divider;
// the GCD by subtract-and-shift.
// The most negative input code is taken as the largest negative magnitude.
// Control is a twelve-word microprogram; see fgr_seq for the listing.

module fraction_gcd_reducer_top (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  wire fgr_pkg::fgr_in_t  in_data,
  output logic                   out_valid,
  output fgr_pkg::fgr_out_t      out_data
);
  import fgr_pkg::*;

  fgr_ucw_t    ctl;      // current control word
  fgr_status_t status;   // datapath flags for the jump logic

  fgr_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .ctl    (ctl),
    .busy   (busy)
  );

  fgr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .ctl       (ctl),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* hw/rtl/fgr_checker.sv */
// Port-level checker for the fraction reducer, bound to the top level.
`default_nettype none

`include "fraction_gcd_reducer_top_defines.svh"

module fgr_checker (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    start,
  input wire                    busy,
  input wire                    out_valid,
  input wire fgr_pkg::fgr_out_t out_data
);
  import fgr_pkg::*;

  `FGR_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted word did not raise busy")
  `FGR_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid, "result strobe longer than one cycle")
  `FGR_ASSERT_SAME(a_result_idle, clk, rst_n, out_valid, !busy, "result shown while still busy")
  `FGR_ASSERT_SAME(a_err_value, clk, rst_n, out_valid && out_data.divide_error, (out_data.reduced_numerator == '0) && (out_data.reduced_denominator == MAG_W'(1)) && out_data.is_whole, "error result is not 0/1")

endmodule

bind fraction_gcd_reducer_top fgr_checker u_fgr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
